@@ src/assert_macros.svh @@
// assertion macros of the scan sequencer rtl, used by the back stage
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHECK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/jss_pkg.sv @@
// shared types and constants of the jtag scan sequencer
package jss_pkg;

    localparam int IR_LEN = 5;
    localparam int DR_LEN = 32;
    localparam int WORD_W = 32;
    localparam int POS_W  = 6;
    localparam int IDX_W  = 5;
    localparam int PLAN_W = POS_W + 1;
    localparam int RESET_TMS_TICKS = 6;

    localparam logic [WORD_W-1:0] IR_MASK = WORD_W'((64'd1 << IR_LEN) - 64'd1);
    localparam logic [WORD_W-1:0] DR_MASK = WORD_W'((64'd1 << DR_LEN) - 64'd1);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [2:0] FUNC_RESET  = 3'd0;
    localparam logic [2:0] FUNC_IR     = 3'd1;
    localparam logic [2:0] FUNC_DR     = 3'd2;
    localparam logic [2:0] FUNC_DR_PAD = 3'd3;
    localparam logic [2:0] FUNC_TICK   = 3'd4;

    typedef enum logic [1:0] {
        KIND_RESET  = 2'd0,
        KIND_IR     = 2'd1,
        KIND_DR     = 2'd2,
        KIND_DR_PAD = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_NOP  = 2'd0,
        OP_CMD  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        t_kind             kind;
        logic [WORD_W-1:0] word;
        logic              tdo;
    } t_item;

    typedef struct packed {
        logic              tck_pulse;
        logic              tms;
        logic              tdi;
        logic              scan_done;
        logic [WORD_W-1:0] captured_word;
        logic              status;
    } t_result;

endpackage

@@ src/jtag_scan_sequencer.sv @@
// top level of the jtag scan sequencer: front stage, queue and back stage
//
// channel  direction  handshake                     payload
// s_axis   in         s_axis_tvalid/s_axis_tready   tdata, tuser (func)
// m_axis   out        m_axis_tvalid/m_axis_tready   tdata, tlast (scan_done), tuser (status)
//
// one item per clock while m_axis does not stall; each item gives one result, registered
// in turn by the front register, the two-entry queue and the result register
// reset is synchronous, active low, and clears the valid flags and the tap sequence state
// a stall on m_axis fills the result register, then the queue, then the front register
module jtag_scan_sequencer
    import jss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word[31:0], tdo_level[32], zero pad
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // tck_pulse[0], tms[1], tdi[2], captured_word[34:3], pad
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // status
);

    logic    front_valid;
    logic    front_ready;
    t_item   front_item;
    logic    queue_valid;
    logic    queue_ready;
    t_item   queue_item;
    t_result result;

    jss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_func  (s_axis_tuser),
        .i_word  (s_axis_tdata[WORD_W-1:0]),
        .i_tdo   (s_axis_tdata[WORD_W]),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_item  (front_item)
    );

    jss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_item  (queue_item)
    );

    jss_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .o_ready  (queue_ready),
        .i_item   (queue_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {5'd0, result.captured_word, result.tdi, result.tms, result.tck_pulse};
    assign m_axis_tlast = result.scan_done;
    assign m_axis_tuser = result.status;

endmodule

@@ src/jss_front.sv @@
// front stage: accepts input transfers and classifies them into queue items
module jss_front
    import jss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_func,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_tdo,
    output logic              o_valid,
    input  logic              i_ready,
    output t_item             o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.kind = t_kind'(i_func[1:0]);
        n_item.word = i_word;
        n_item.tdo  = i_tdo;
        unique case (i_func) inside
            FUNC_RESET, FUNC_IR, FUNC_DR, FUNC_DR_PAD: n_item.op = OP_CMD;
            FUNC_TICK:                                 n_item.op = OP_TICK;
            default:                                   n_item.op = OP_NOP;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

@@ src/jss_queue.sv @@
// two-entry queue between the front and back stages
module jss_queue
    import jss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ src/jss_back.sv @@
// back stage: runs the tap sequences and registers one result per item
`include "assert_macros.svh"

module jss_back
    import jss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_kind             r_kind;
    t_kind             n_kind;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [WORD_W-1:0] r_out_shift;
    logic [WORD_W-1:0] n_out_shift;
    logic [WORD_W-1:0] r_in_shift;
    logic [WORD_W-1:0] n_in_shift;
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;

    logic              pop;
    logic [PLAN_W-1:0] pos_x;
    logic [PLAN_W-1:0] pre;
    logic [PLAN_W-1:0] len;
    logic [PLAN_W-1:0] shift_end;
    logic [PLAN_W-1:0] idx_x;
    logic [IDX_W-1:0]  idx;
    logic              plan_tms;
    logic              shifting;
    logic              last;

    assign o_ready  = !r_out_valid || i_ready;
    assign pop      = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // tick plan for the current position
    always_comb begin
        pos_x     = {1'b0, r_pos};
        pre       = (r_kind == KIND_IR || r_kind == KIND_DR_PAD) ? PLAN_W'(4) : PLAN_W'(3);
        len       = (r_kind == KIND_IR) ? PLAN_W'(IR_LEN) : PLAN_W'(DR_LEN);
        shift_end = pre + len;
        idx_x     = pos_x - pre;
        idx       = idx_x[IDX_W-1:0];
        shifting  = 1'b0;
        plan_tms  = 1'b0;
        if (r_kind == KIND_RESET) begin
            plan_tms = (pos_x < PLAN_W'(RESET_TMS_TICKS));
            last     = !plan_tms;
        end else begin
            last = (pos_x + PLAN_W'(1) >= shift_end + PLAN_W'(2));
            if (pos_x < pre) begin
                plan_tms = (r_kind == KIND_IR) ? (pos_x < PLAN_W'(2)) : (pos_x == '0);
            end else if (pos_x < shift_end) begin
                shifting = 1'b1;
                plan_tms = (idx_x == len - PLAN_W'(1));
            end else if (pos_x == shift_end) begin
                plan_tms = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_pos       = r_pos;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_out       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item.op == OP_CMD) begin
                    n_state    = ST_SCAN;
                    n_kind     = i_item.kind;
                    n_pos      = '0;
                    n_in_shift = '0;
                    case (i_item.kind)
                        KIND_RESET: n_out_shift = '0;
                        KIND_IR:    n_out_shift = i_item.word & IR_MASK;
                        default:    n_out_shift = i_item.word & DR_MASK;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_item.op == OP_CMD) begin
                    n_out.status = 1'b1;
                end else if (i_item.op == OP_TICK) begin
                    n_out.tck_pulse = 1'b1;
                    n_out.tms       = plan_tms;
                    if (shifting) begin
                        n_out.tdi  = r_out_shift[idx];
                        n_in_shift = r_in_shift | (WORD_W'(i_item.tdo) << idx);
                    end
                    if (last) begin
                        n_out.scan_done     = 1'b1;
                        n_out.captured_word = n_in_shift;
                        n_state             = ST_IDLE;
                        n_pos               = '0;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= KIND_RESET;
            r_pos       <= '0;
            r_out_shift <= '0;
            r_in_shift  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_state     <= n_state;
                r_kind      <= n_kind;
                r_pos       <= n_pos;
                r_out_shift <= n_out_shift;
                r_in_shift  <= n_in_shift;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    `CHECK_NEXT(a_done_ends_scan, i_clk, i_rst_n,
        pop && r_state == ST_SCAN && i_item.op == OP_TICK && last,
        r_state == ST_IDLE && r_out.scan_done, "final tick did not end the sequence")
    `CHECK_NEXT(a_refuse_keeps_state, i_clk, i_rst_n,
        pop && r_state == ST_SCAN && i_item.op == OP_CMD,
        r_state == ST_SCAN && $stable(r_kind) && $stable(r_pos) && r_out.status,
        "refused command changed the sequence")
    `CHECK_NEXT(a_stall_holds_result, i_clk, i_rst_n,
        r_out_valid && !i_ready, r_out_valid && $stable(r_out), "stalled result was lost")
    `CHECK_IMPL(a_pulse_only_in_scan, i_clk, i_rst_n,
        r_out_valid && r_out.scan_done, r_out.tck_pulse && !r_out.status,
        "scan done without a tck pulse")

endmodule

@@ test/tb_top.sv @@
// testbench of the jtag scan sequencer: predicted tap ticks checked against the stream output
`timescale 1ns / 100ps

module tb_top;
    import jss_pkg::*;

    localparam int N_ITEMS = 1800;
    localparam int STALL_PCT = 38;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [2:0] FUNC_UNDEF_LO = 3'd5;
    localparam logic [2:0] FUNC_UNDEF_HI = 3'd7;

    class scan_checker;
        bit                busy;
        t_kind             kind;
        int                tick_pos;
        logic [WORD_W-1:0] out_bits;
        logic [WORD_W-1:0] in_bits;
        t_result           pending_results[$];
        int                mismatches;

        function new();
            busy = 1'b0;
            kind = KIND_RESET;
            tick_pos = 0;
            out_bits = '0;
            in_bits = '0;
            mismatches = 0;
        endfunction

        // predicts the tap activity caused by one accepted input transfer
        function void note_item(logic [2:0] func, logic [WORD_W-1:0] word, logic tdo);
            t_result r;
            int      pre;
            int      len;
            int      idx;
            bit      shifting;
            bit      last;
            bit      tms;
            r = '0;
            shifting = 1'b0;
            idx = 0;
            if (func <= FUNC_DR_PAD) begin
                if (busy) begin
                    r.status = 1'b1;
                end else begin
                    busy = 1'b1;
                    kind = t_kind'(func[1:0]);
                    tick_pos = 0;
                    in_bits = '0;
                    if (func == FUNC_RESET) out_bits = '0;
                    else if (func == FUNC_IR) out_bits = word & IR_MASK;
                    else out_bits = word & DR_MASK;
                end
            end else if (func == FUNC_TICK && busy) begin
                if (kind == KIND_RESET) begin
                    tms = tick_pos < RESET_TMS_TICKS;
                    last = tick_pos >= RESET_TMS_TICKS;
                end else begin
                    pre = (kind == KIND_DR) ? 3 : 4;
                    len = (kind == KIND_IR) ? IR_LEN : DR_LEN;
                    last = tick_pos + 1 >= pre + len + 2;
                    if (tick_pos < pre) begin
                        tms = (kind == KIND_IR) ? (tick_pos < 2) : (tick_pos == 0);
                    end else if (tick_pos < pre + len) begin
                        shifting = 1'b1;
                        idx = tick_pos - pre;
                        tms = idx == len - 1;
                    end else begin
                        tms = tick_pos == pre + len;
                    end
                end
                r.tck_pulse = 1'b1;
                r.tms = tms;
                if (shifting) begin
                    r.tdi = out_bits[idx];
                    in_bits[idx] = in_bits[idx] | tdo;
                end
                if (last) begin
                    r.scan_done = 1'b1;
                    r.captured_word = in_bits;
                    busy = 1'b0;
                    tick_pos = 0;
                end else begin
                    tick_pos = (tick_pos + 1) % 64;
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.tck_pulse !== want.tck_pulse || got.tms !== want.tms
                    || got.tdi !== want.tdi || got.scan_done !== want.scan_done
                    || got.captured_word !== want.captured_word
                    || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // data_word[31:0], tdo_level[32], zero pad
    logic [2:0]  s_axis_tuser = '0;   // func[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // tck_pulse[0], tms[1], tdi[2], captured_word[34:3], pad
    logic        m_axis_tlast;
    logic        m_axis_tuser;       // status

    scan_checker checker_h = new();
    bit          steady = 1'b0;
    int          quiet_cycles = 0;
    int          sent = 0;

    jtag_scan_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit stall_roll();
        return !steady && ($urandom_range(0, 99) < STALL_PCT);
    endfunction

    task automatic send_item(input logic [2:0] func, input logic [31:0] word, input logic tdo);
        while (stall_roll()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, tdo, word};
        s_axis_tuser <= func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        checker_h.note_item(func, word, tdo);
    endtask

    task automatic send_noise();
        logic [2:0] func;
        func = $urandom_range(0, 1) ? 3'($urandom_range(FUNC_RESET, FUNC_DR_PAD))
                                     : 3'($urandom_range(FUNC_UNDEF_LO, FUNC_UNDEF_HI));
        send_item(func, $urandom, 1'($urandom));
    endtask

    // result side: check each transfer, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            checker_h.check_result('{tck_pulse: m_axis_tdata[0], tms: m_axis_tdata[1],
                                     tdi: m_axis_tdata[2], scan_done: m_axis_tlast,
                                     captured_word: m_axis_tdata[34:3],
                                     status: m_axis_tuser});
        m_axis_tready <= i_rst_n && !stall_roll();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [2:0]  func;
        logic [31:0] word;
        int          n_ticks;
        int          tdo_mode;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick while idle, undefined codes, reset sequence with refused commands
        send_item(FUNC_TICK, 32'hFFFF_FFFF, 1'b1);
        for (int f = FUNC_UNDEF_LO; f <= FUNC_UNDEF_HI; f++)
            send_item(3'(f), $urandom, 1'b1);
        send_item(FUNC_RESET, 32'hFFFF_FFFF, 1'b0);
        for (int f = FUNC_RESET; f <= FUNC_DR_PAD; f++)
            send_item(3'(f), 32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < RESET_TMS_TICKS + 1; i++)
            send_item(FUNC_TICK, $urandom, 1'b1);
        // instruction scan with all ones, upper bits beyond the register too
        send_item(FUNC_IR, 32'hFFFF_FFFF, 1'b0);
        for (int i = 0; i < IR_LEN + 6; i++)
            send_item(FUNC_TICK, 32'h0, 1'b1);

        while (sent < N_ITEMS) begin
            steady = (sent >= 700) && (sent < 1000);
            func = 3'($urandom_range(FUNC_RESET, FUNC_DR_PAD));
            case ($urandom_range(0, 7))
                0: word = '0;
                1: word = '1;
                default: word = $urandom;
            endcase
            case (func)
                FUNC_RESET: n_ticks = RESET_TMS_TICKS + 1;
                FUNC_IR:    n_ticks = IR_LEN + 6;
                FUNC_DR:    n_ticks = DR_LEN + 5;
                default:    n_ticks = DR_LEN + 6;
            endcase
            // some sequences are cut short or run on into idle ticks
            case ($urandom_range(0, 9))
                0: n_ticks = $urandom_range(0, n_ticks - 1);
                1: n_ticks = n_ticks + $urandom_range(1, 3);
                default: ;
            endcase
            tdo_mode = $urandom_range(0, 5);
            send_item(func, word, 1'($urandom));
            sent++;
            for (int i = 0; i < n_ticks; i++) begin
                if ($urandom_range(0, 99) < 6) send_noise();
                send_item(FUNC_TICK, $urandom,
                          tdo_mode == 0 ? 1'b0 : tdo_mode == 1 ? 1'b1 : 1'($urandom));
                sent++;
            end
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (checker_h.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (checker_h.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ jtag_scan_sequencer.f @@
+incdir+src
src/jss_pkg.sv
src/jss_front.sv
src/jss_queue.sv
src/jss_back.sv
src/jtag_scan_sequencer.sv
test/tb_top.sv
